FILE: rtl/biclique_k4_6_edge_check_macros.svh
// Assertion macros for the biclique edge check.
// Included by files that carry concurrent assertions; expects clk and rst in scope.
`ifndef BICLIQUE_K4_6_EDGE_CHECK_MACROS_SVH
`define BICLIQUE_K4_6_EDGE_CHECK_MACROS_SVH

// same-cycle implication
`define BKC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bkc_pkg.sv
// Shared constants, command/status types and bit-count helpers for the biclique edge check.
// No dependencies.
`default_nettype none

package bkc_pkg;

  localparam int NUM_ROWS   = 32;
  localparam int ROW_W      = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;
  localparam int CFG_W      = 6;
  localparam int MIN_SHARED = 5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic query_load;
    logic row_write;
    logic u_load;
    logic scan_start;
    logic scan_run;
    logic i_init;
    logic i_load;
    logic i_next;
    logic j_init;
    logic j_sel;
    logic j_load;
    logic j_next;
    logic k_init;
    logic k_run;
    logic res_load;
    logic res_found;
  } bkc_cmd_t;

  typedef struct packed {
    logic urow_ok;
    logic scan_done;
    logic i_end;
    logic ci_ok;
    logic j_end;
    logic ij_ok;
    logic k_hit;
    logic k_done;
    logic res_free;
  } bkc_sts_t;

  function automatic logic [CNT_W-1:0] popcnt(input logic [ROW_W-1:0] x);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int b = 0; b < ROW_W; b++) begin
      c = c + CNT_W'(x[b]);
    end
    return c;
  endfunction

  function automatic logic enough_cols(input logic [ROW_W-1:0] x);
    return popcnt(x) >= CNT_W'(MIN_SHARED);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bkc_datapath.sv
// Datapath: adjacency store, candidate store, loop counters, bit-count checks, result register.
// Depends on bkc_pkg; driven by bkc_ctrl through bkc_cmd_t.
`default_nettype none

module bkc_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [bkc_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [bkc_pkg::IDX_W-1:0]  row_index,
  input  wire logic [bkc_pkg::ROW_W-1:0]  row_bits,
  input  wire logic [bkc_pkg::IDX_W-1:0]  query_row,
  input  wire logic [bkc_pkg::IDX_W-1:0]  query_col,
  input  wire bkc_pkg::bkc_cmd_t          cmd,
  output bkc_pkg::bkc_sts_t               sts,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output logic                            found
);
  import bkc_pkg::*;

  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [IDX_W-1:0] u;
  logic [IDX_W-1:0] v;

  logic [ROW_W-1:0] adj_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] adj_vld;
  logic [ROW_W-1:0] adj_q;
  logic             adj_q_vld;
  logic [ROW_W-1:0] adj_row;
  logic [IDX_W-1:0] adj_addr;

  logic [ROW_W-1:0] cand_mem [NUM_ROWS];
  logic [ROW_W-1:0] cand_q;
  logic [IDX_W-1:0] cand_addr;

  logic [ROW_W-1:0] urow;
  logic [ROW_W-1:0] ci;
  logic [ROW_W-1:0] ij;
  logic [CNT_W-1:0] nc;
  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] k;
  logic             scan_pend;
  logic [IDX_W-1:0] scan_idx;
  logic             k_pend;

  logic [CNT_W-1:0] m;
  logic [CNT_W-1:0] n;
  logic [ROW_W-1:0] col_mask;
  logic             scan_issue;
  logic             k_issue;
  logic             cand_take;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_W'(NUM_ROWS);
      cols_in_use <= CFG_W'(NUM_ROWS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m = (rows_in_use > CNT_W'(NUM_ROWS)) ? CNT_W'(NUM_ROWS) : rows_in_use;
  assign n = (cols_in_use > CNT_W'(NUM_ROWS)) ? CNT_W'(NUM_ROWS) : cols_in_use;

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      col_mask[c] = (CNT_W'(c) < n) && (IDX_W'(c) != v);
    end
  end

  // adjacency store
  assign adj_addr = cmd.scan_run ? r[IDX_W-1:0] : u;

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_vld <= '0;
    end else if (cmd.row_write) begin
      adj_vld[row_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_write) begin
      adj_mem[row_index] <= row_bits;
    end
    adj_q     <= adj_mem[adj_addr];
    adj_q_vld <= adj_vld[adj_addr];
  end

  assign adj_row = adj_q_vld ? adj_q : '0;

  // candidate gather
  assign scan_issue = cmd.scan_run && (r < m);
  assign cand_take  = cmd.scan_run && scan_pend && (scan_idx != u) && adj_row[v];

  always_ff @(posedge clk) begin
    if (cmd.query_load) begin
      u <= query_row;
      v <= query_col;
    end
    if (cmd.u_load) begin
      urow <= adj_row & col_mask;
    end
    if (cmd.scan_start) begin
      r  <= '0;
      nc <= '0;
    end else if (cmd.scan_run) begin
      if (scan_issue) begin
        r <= r + CNT_W'(1);
      end
      if (cand_take) begin
        nc <= nc + CNT_W'(1);
      end
    end
    scan_idx <= r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
    end else begin
      scan_pend <= scan_issue;
    end
  end

  // candidate store
  assign cand_addr = cmd.k_run ? k[IDX_W-1:0] : (cmd.j_sel ? j[IDX_W-1:0] : i[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (cand_take) begin
      cand_mem[nc[IDX_W-1:0]] <= adj_row & urow;
    end
    cand_q <= cand_mem[cand_addr];
  end

  // triple search
  assign k_issue = cmd.k_run && (k < nc);

  always_ff @(posedge clk) begin
    if (cmd.i_init) begin
      i <= '0;
    end else if (cmd.i_next) begin
      i <= i + CNT_W'(1);
    end
    if (cmd.i_load) begin
      ci <= cand_q;
    end
    if (cmd.j_init) begin
      j <= i + CNT_W'(1);
    end else if (cmd.j_next) begin
      j <= j + CNT_W'(1);
    end
    if (cmd.j_load) begin
      ij <= ci & cand_q;
    end
    if (cmd.k_init) begin
      k <= j + CNT_W'(1);
    end else if (k_issue) begin
      k <= k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_pend <= 1'b0;
    end else begin
      k_pend <= k_issue;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      found <= cmd.res_found;
    end
  end

  always_comb begin
    sts.urow_ok   = enough_cols(urow);
    sts.scan_done = (r >= m) && !scan_pend;
    sts.i_end     = ({1'b0, i} + (CNT_W + 1)'(2)) >= {1'b0, nc};
    sts.ci_ok     = enough_cols(cand_q);
    sts.j_end     = ({1'b0, j} + (CNT_W + 1)'(1)) >= {1'b0, nc};
    sts.ij_ok     = enough_cols(ci & cand_q);
    sts.k_hit     = k_pend && enough_cols(ij & cand_q);
    sts.k_done    = (k >= nc) && !k_pend;
    sts.res_free  = !res_valid || !res_stall;
  end

endmodule

`default_nettype wire

FILE: rtl/bkc_ctrl.sv
// Controller state machine: sequences row writes, candidate gather and the triple search.
// Depends on bkc_pkg; commands bkc_datapath through bkc_cmd_t.
`default_nettype none

module bkc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic              func,
  input  wire bkc_pkg::bkc_sts_t sts,
  output bkc_pkg::bkc_cmd_t      cmd
);
  import bkc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDU  = 4'd1;
  localparam logic [3:0] S_LDU  = 4'd2;
  localparam logic [3:0] S_CHKU = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_IRD  = 4'd5;
  localparam logic [3:0] S_ILD  = 4'd6;
  localparam logic [3:0] S_JRD  = 4'd7;
  localparam logic [3:0] S_JLD  = 4'd8;
  localparam logic [3:0] S_K    = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       hit;
  logic       hit_next;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      hit   <= hit_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    hit_next   = hit;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (func == FUNC_QUERY) begin
            cmd.query_load = 1'b1;
            state_next     = S_RDU;
          end else begin
            cmd.row_write = 1'b1;
          end
        end
      end
      S_RDU: state_next = S_LDU;
      S_LDU: begin
        cmd.u_load     = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = S_CHKU;
      end
      S_CHKU: begin
        hit_next   = 1'b0;
        state_next = sts.urow_ok ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          cmd.i_init = 1'b1;
          state_next = S_IRD;
        end
      end
      S_IRD: begin
        state_next = sts.i_end ? S_DONE : S_ILD;
      end
      S_ILD: begin
        if (sts.ci_ok) begin
          cmd.i_load = 1'b1;
          cmd.j_init = 1'b1;
          state_next = S_JRD;
        end else begin
          cmd.i_next = 1'b1;
          state_next = S_IRD;
        end
      end
      S_JRD: begin
        if (sts.j_end) begin
          cmd.i_next = 1'b1;
          state_next = S_IRD;
        end else begin
          cmd.j_sel  = 1'b1;
          state_next = S_JLD;
        end
      end
      S_JLD: begin
        if (sts.ij_ok) begin
          cmd.j_load = 1'b1;
          cmd.k_init = 1'b1;
          state_next = S_K;
        end else begin
          cmd.j_next = 1'b1;
          state_next = S_JRD;
        end
      end
      S_K: begin
        cmd.k_run = 1'b1;
        if (sts.k_hit) begin
          hit_next   = 1'b1;
          state_next = S_DONE;
        end else if (sts.k_done) begin
          cmd.j_next = 1'b1;
          state_next = S_JRD;
        end
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = hit;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/biclique_k4_6_edge_check.sv
// Write item: taken at once, no result; the next request can follow immediately.
// Query: gathers candidates over the rows in use, then the triple search reads one candidate
// per cycle through the single read port of the candidate store (about C(nc,3) inner steps);
// one query at a time.
// Reset (synchronous, active high) clears the adjacency store and sets both counts to 32.
`default_nettype none
`include "biclique_k4_6_edge_check_macros.svh"

module biclique_k4_6_edge_check (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [bkc_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic                       func,
  input  wire logic [bkc_pkg::IDX_W-1:0]  row_index,
  input  wire logic [bkc_pkg::ROW_W-1:0]  row_bits,
  input  wire logic [bkc_pkg::IDX_W-1:0]  query_row,
  input  wire logic [bkc_pkg::IDX_W-1:0]  query_col,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output logic                            found
);
  import bkc_pkg::*;

  bkc_cmd_t cmd;
  bkc_sts_t sts;

  bkc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .sts       (sts),
    .cmd       (cmd)
  );

  bkc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_index (row_index),
    .row_bits  (row_bits),
    .query_row (query_row),
    .query_col (query_col),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .found     (found)
  );

  `BKC_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && (func == FUNC_QUERY), req_stall, "query request did not start a search")
  `BKC_ASSERT_NEXT(a_write_free, req_valid && !req_stall && (func == FUNC_WRITE), !req_stall, "row write blocked the request channel")
  `BKC_ASSERT_IMP(a_res_from_query, $rose(res_valid), $past(req_stall), "result without a query in progress")

endmodule

`default_nettype wire

FILE: tb/biclique_found_checker.sv
// Watches the request, result and register ports of the biclique edge check,
// predicts every query answer from its own copy of the store and counts, and compares.
// Depends on bkc_pkg for widths and codes.
`timescale 1ns / 1ps

module biclique_found_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bkc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      req_valid,
  input  logic                      req_stall,
  input  logic                      func,
  input  logic [bkc_pkg::IDX_W-1:0] row_index,
  input  logic [bkc_pkg::ROW_W-1:0] row_bits,
  input  logic [bkc_pkg::IDX_W-1:0] query_row,
  input  logic [bkc_pkg::IDX_W-1:0] query_col,
  input  logic                      res_valid,
  input  logic                      res_stall,
  input  logic                      found,
  output int                        fail_count,
  output int                        pending,
  output int                        checked,
  output int                        hits
);
  import bkc_pkg::*;

  logic [ROW_W-1:0] adj_rows [NUM_ROWS];
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  logic             expected_found [$];

  // true when u, three other rows with an edge at v and five columns besides v
  // form a complete four by six block
  function automatic logic predict_found(input logic [IDX_W-1:0] u, input logic [IDX_W-1:0] v);
    int          m;
    int          n;
    int          nc;
    int          r;
    int          i;
    int          j;
    int          k;
    logic [ROW_W-1:0] col_mask;
    logic [ROW_W-1:0] urow;
    logic [ROW_W-1:0] ij;
    logic [ROW_W-1:0] cand [NUM_ROWS];
    m  = (row_count > NUM_ROWS) ? NUM_ROWS : int'(row_count);
    n  = (col_count > ROW_W) ? ROW_W : int'(col_count);
    col_mask = (n >= ROW_W) ? '1 : ((32'd1 << n) - 32'd1);
    col_mask = col_mask & ~(32'd1 << v);
    urow = adj_rows[u] & col_mask;
    if ($countones(urow) < MIN_SHARED) return 1'b0;
    nc = 0;
    for (r = 0; r < m; r++) begin
      if (r != int'(u) && adj_rows[r][v]) begin
        cand[nc] = adj_rows[r] & urow;
        nc++;
      end
    end
    for (i = 0; i < nc; i++) begin
      if ($countones(cand[i]) >= MIN_SHARED) begin
        for (j = i + 1; j < nc; j++) begin
          ij = cand[i] & cand[j];
          if ($countones(ij) >= MIN_SHARED) begin
            for (k = j + 1; k < nc; k++) begin
              if ($countones(ij & cand[k]) >= MIN_SHARED) return 1'b1;
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : track
    logic want;
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) adj_rows[r] = '0;
      row_count = CFG_W'(32);
      col_count = CFG_W'(32);
      expected_found.delete();
    end else begin
      // result first: it can only belong to an earlier query
      if (res_valid && !res_stall) begin
        if (expected_found.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none actual found=%0b",
                   $time, found);
          fail_count++;
        end else begin
          want = expected_found.pop_front();
          checked++;
          if (found !== want) begin
            $display("%0t: found mismatch on result %0d, expected %0b actual %0b",
                     $time, checked, want, found);
            fail_count++;
          end else if (want) begin
            hits++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        if (func == FUNC_WRITE) adj_rows[row_index] = row_bits;
        else expected_found.insert(expected_found.size(), predict_found(query_row, query_col));
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) row_count = cfg_data;
        else col_count = cfg_data;
      end
    end
    pending = expected_found.size();
  end

endmodule

FILE: tb/tb_biclique_k4_6_edge_check.sv
// Top of the biclique edge check testbench: clock, reset, bursty request stimulus with
// planted four by six blocks, result stall patterns and the verdict.
// Depends on bkc_pkg, biclique_k4_6_edge_check and biclique_found_checker.
`timescale 1ns / 1ps

module tb_biclique_k4_6_edge_check;
  import bkc_pkg::*;

  localparam int LIMIT_CYCLES  = 10_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES   = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_PHASES    = 7;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_ROWS;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             req_valid = 1'b0;
  logic             func      = FUNC_WRITE;
  logic [IDX_W-1:0] row_index = '0;
  logic [ROW_W-1:0] row_bits  = '0;
  logic [IDX_W-1:0] query_row = '0;
  logic [IDX_W-1:0] query_col = '0;
  logic             res_stall = 1'b0;
  wire              req_stall;
  wire              res_valid;
  wire              found;

  int   fails;
  int   pending;
  int   checked;
  int   hits;
  logic hold_off_req = 1'b0;
  int   cycles     = 0;
  int   burst_left = 0;
  int   writes     = 0;
  int   queries    = 0;
  int   reg_writes = 0;
  int   rows_cfg   = 32;
  int   cols_cfg   = 32;
  int   phase_rows [NUM_PHASES] = '{32, 63, 12, 4, 32, 0, 20};
  int   phase_cols [NUM_PHASES] = '{32, 63, 20, 6, 7, 32, 0};

  biclique_k4_6_edge_check dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .row_index (row_index),
    .row_bits  (row_bits),
    .query_row (query_row),
    .query_col (query_col),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .found     (found)
  );

  biclique_found_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .query_row  (query_row),
    .query_col  (query_col),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .found      (found),
    .fail_count (fails),
    .pending    (pending),
    .checked    (checked),
    .hits       (hits)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // result side stall patterns; a hold-off request gives one long stall
  initial begin : res_pacing
    stall_mode_t mode;
    int          span;
    logic        hold_done;
    hold_done = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        mode = STALL_HOLD;
        span = HOLD_CYCLES;
      end
      repeat (span) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:   res_stall <= 1'b0;
          STALL_SPARSE: res_stall <= ($urandom_range(0, 2) == 0);
          STALL_HALF:   res_stall <= ($urandom_range(0, 1) == 0);
          STALL_HEAVY:  res_stall <= ($urandom_range(0, 3) != 0);
          default:      res_stall <= 1'b1;
        endcase
      end
    end
  end

  // one request; valid stays up inside a burst, drops for a gap at its end
  task automatic send_req(input logic f, input logic [IDX_W-1:0] ri, input logic [ROW_W-1:0] rb,
                          input logic [IDX_W-1:0] qr, input logic [IDX_W-1:0] qc);
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    req_valid <= 1'b1;
    func      <= f;
    row_index <= ri;
    row_bits  <= rb;
    query_row <= qr;
    query_col <= qc;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
    if (f == FUNC_WRITE) writes++;
    else queries++;
    burst_left--;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic write_row(input logic [IDX_W-1:0] ri, input logic [ROW_W-1:0] rb);
    send_req(FUNC_WRITE, ri, rb, IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic query(input logic [IDX_W-1:0] qr, input logic [IDX_W-1:0] qc);
    send_req(FUNC_QUERY, IDX_W'($urandom), $urandom, qr, qc);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == REG_ROWS) rows_cfg = val;
    else cols_cfg = val;
  endtask

  // mostly planted blocks (sometimes with one edge knocked out), plus loose writes and queries
  task automatic random_phase(input int n);
    int               done;
    int               rlim;
    int               clim;
    int               pick;
    int               k;
    int               c;
    int               qpick;
    int               brk;
    int               qcol;
    logic [IDX_W-1:0] prow [4];
    logic [ROW_W-1:0] used_rows;
    logic [ROW_W-1:0] pcols;
    logic [ROW_W-1:0] bits;
    rlim = (rows_cfg >= 4 && rows_cfg <= NUM_ROWS) ? rows_cfg : NUM_ROWS;
    clim = (cols_cfg >= 6 && cols_cfg <= ROW_W) ? cols_cfg : ROW_W;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        used_rows = '0;
        for (k = 0; k < 4; k++) begin
          do prow[k] = IDX_W'($urandom_range(0, rlim - 1)); while (used_rows[prow[k]]);
          used_rows[prow[k]] = 1'b1;
        end
        pcols = '0;
        qpick = $urandom_range(0, 5);
        qcol  = 0;
        for (k = 0; k < 6; k++) begin
          do c = $urandom_range(0, clim - 1); while (pcols[c]);
          pcols[c] = 1'b1;
          if (k == qpick) qcol = c;
        end
        brk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1;
        for (k = 0; k < 4; k++) begin
          bits = pcols | ($urandom & $urandom & $urandom);
          if (k == brk) begin
            c = $urandom_range(0, clim - 1);
            bits[c] = 1'b0;
          end
          write_row(prow[k], bits);
        end
        k = $urandom_range(0, 3);
        query(prow[k], IDX_W'(qcol));
        done += 5;
      end else if (pick < 82) begin
        write_row(IDX_W'($urandom), ($urandom_range(0, 1) != 0) ? $urandom : ($urandom & $urandom));
        done++;
      end else begin
        query(IDX_W'($urandom), IDX_W'($urandom));
        done++;
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty store, then full rows with edge v at both ends of the column range
    query(0, 0);
    write_row(0, '1);
    write_row(1, '1);
    write_row(2, '1);
    write_row(31, '1);
    query(0, 31);
    query(31, 0);
    query(5, 5);
    // only two candidate rows left
    write_row(2, '0);
    query(0, 5);
    // third row shares exactly five columns, then four, then five beside v = 31
    write_row(3, 32'h0000_003F);
    query(0, 0);
    query(0, 6);
    write_row(3, 32'h0000_001F);
    query(0, 0);
    write_row(3, 32'h8000_003E);
    query(0, 31);

    // few rows in use, query row above them, saturating counts, column outside the range
    write_reg(REG_ROWS, 3);
    query(0, 31);
    query(31, 0);
    write_reg(REG_ROWS, 63);
    query(0, 31);
    write_reg(REG_COLS, 0);
    query(0, 31);
    write_reg(REG_COLS, 6);
    query(0, 0);
    query(0, 7);
    write_reg(REG_COLS, 63);
    query(1, 3);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_ROWS, phase_rows[ph]);
      write_reg(REG_COLS, phase_cols[ph]);
      if (ph == 0) hold_off_req = 1'b1;
      random_phase((phase_rows[ph] == 0 || phase_cols[ph] == 0) ? 8 : 20);
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("run covered %0d requests (%0d row writes, %0d queries) over %0d register writes",
             writes + queries, writes, queries, reg_writes);
    $display("%0d answers compared, %0d with a block found, %0d mismatches", checked, hits, fails);
    if (fails == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
